// File: hdl/kuz_pkg.sv
// Kuznyechik shared package: S-boxes, GF(2^8) multiply, L/inverse-L layers, controller commands.
// No dependencies.
`default_nettype none
package kuz_pkg;

    localparam int BlockWidth = 128;
    localparam int KeyWordWidth = 64;
    localparam int RoundKeyCountDefault = 10;
    localparam int AddrWidth = 5;

    localparam logic [1:0] RegKey0 = 2'd0;
    localparam logic [1:0] RegKey1 = 2'd1;
    localparam logic [1:0] RegKey2 = 2'd2;
    localparam logic [1:0] RegKey3 = 2'd3;

    localparam logic CmdEncrypt = 1'b0;
    localparam logic CmdDecrypt = 1'b1;

    typedef logic [BlockWidth-1:0] block_t;

    // controller -> datapath
    typedef struct packed {
        logic key_load;    // load key registers into expansion regs and round keys 0,1
        logic exp_step;    // one Feistel step of key expansion
        logic exp_store;   // store current a/b pair into round keys
        logic [3:0] exp_pair;
        logic [5:0] exp_const; // constant index 1..32
        logic blk_load;
        logic blk_round;   // one full round
        logic blk_final;   // final key xor into output register
        logic [3:0] rk_idx;
    } kuz_cmd_t;

    localparam logic [7:0] SBOX [256] = '{
        8'd252,8'd238,8'd221,8'd17,8'd207,8'd110,8'd49,8'd22,
        8'd251,8'd196,8'd250,8'd218,8'd35,8'd197,8'd4,8'd77,
        8'd233,8'd119,8'd240,8'd219,8'd147,8'd46,8'd153,8'd186,
        8'd23,8'd54,8'd241,8'd187,8'd20,8'd205,8'd95,8'd193,
        8'd249,8'd24,8'd101,8'd90,8'd226,8'd92,8'd239,8'd33,
        8'd129,8'd28,8'd60,8'd66,8'd139,8'd1,8'd142,8'd79,
        8'd5,8'd132,8'd2,8'd174,8'd227,8'd106,8'd143,8'd160,
        8'd6,8'd11,8'd237,8'd152,8'd127,8'd212,8'd211,8'd31,
        8'd235,8'd52,8'd44,8'd81,8'd234,8'd200,8'd72,8'd171,
        8'd242,8'd42,8'd104,8'd162,8'd253,8'd58,8'd206,8'd204,
        8'd181,8'd112,8'd14,8'd86,8'd8,8'd12,8'd118,8'd18,
        8'd191,8'd114,8'd19,8'd71,8'd156,8'd183,8'd93,8'd135,
        8'd21,8'd161,8'd150,8'd41,8'd16,8'd123,8'd154,8'd199,
        8'd243,8'd145,8'd120,8'd111,8'd157,8'd158,8'd178,8'd177,
        8'd50,8'd117,8'd25,8'd61,8'd255,8'd53,8'd138,8'd126,
        8'd109,8'd84,8'd198,8'd128,8'd195,8'd189,8'd13,8'd87,
        8'd223,8'd245,8'd36,8'd169,8'd62,8'd168,8'd67,8'd201,
        8'd215,8'd121,8'd214,8'd246,8'd124,8'd34,8'd185,8'd3,
        8'd224,8'd15,8'd236,8'd222,8'd122,8'd148,8'd176,8'd188,
        8'd220,8'd232,8'd40,8'd80,8'd78,8'd51,8'd10,8'd74,
        8'd167,8'd151,8'd96,8'd115,8'd30,8'd0,8'd98,8'd68,
        8'd26,8'd184,8'd56,8'd130,8'd100,8'd159,8'd38,8'd65,
        8'd173,8'd69,8'd70,8'd146,8'd39,8'd94,8'd85,8'd47,
        8'd140,8'd163,8'd165,8'd125,8'd105,8'd213,8'd149,8'd59,
        8'd7,8'd88,8'd179,8'd64,8'd134,8'd172,8'd29,8'd247,
        8'd48,8'd55,8'd107,8'd228,8'd136,8'd217,8'd231,8'd137,
        8'd225,8'd27,8'd131,8'd73,8'd76,8'd63,8'd248,8'd254,
        8'd141,8'd83,8'd170,8'd144,8'd202,8'd216,8'd133,8'd97,
        8'd32,8'd113,8'd103,8'd164,8'd45,8'd43,8'd9,8'd91,
        8'd203,8'd155,8'd37,8'd208,8'd190,8'd229,8'd108,8'd82,
        8'd89,8'd166,8'd116,8'd210,8'd230,8'd244,8'd180,8'd192,
        8'd209,8'd102,8'd175,8'd194,8'd57,8'd75,8'd99,8'd182
    };

    localparam logic [7:0] LCOEF [16] = '{
        8'd148,8'd32,8'd133,8'd16,8'd194,8'd192,8'd1,8'd251,
        8'd1,8'd192,8'd194,8'd16,8'd133,8'd32,8'd148,8'd1
    };

    function automatic logic [7:0] sbox_inv(input logic [7:0] x);
        logic [7:0] r;
        r = 8'd0;
        for (int j = 0; j < 256; j++) begin
            if (SBOX[j] == x) r = 8'(j);
        end
        return r;
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        logic [7:0] aa;
        p = 8'd0;
        aa = a;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) p = p ^ aa;
            aa = aa[7] ? ((aa << 1) ^ 8'hC3) : (aa << 1);
        end
        return p;
    endfunction

    // byte i of the block (byte 0 most significant)
    function automatic logic [7:0] byte_at(input block_t v, input int i);
        return v[BlockWidth-1-8*i -: 8];
    endfunction

    function automatic logic [7:0] lin_sum(input block_t v);
        logic [7:0] acc;
        acc = 8'd0;
        for (int i = 0; i < 16; i++) acc = acc ^ gf_mul(LCOEF[i], byte_at(v, i));
        return acc;
    endfunction

    // 16 shifts of the LFSR; each shift is linear so this flattens to an XOR network
    function automatic block_t lin_fwd(input block_t v);
        block_t w;
        w = v;
        for (int r = 0; r < 16; r++) w = {lin_sum(w), w[BlockWidth-1:8]};
        return w;
    endfunction

    function automatic block_t lin_inv(input block_t v);
        block_t w;
        w = v;
        for (int r = 0; r < 16; r++) begin
            w = {w[BlockWidth-9:0], w[BlockWidth-1 -: 8]};
            w[7:0] = lin_sum(w);
        end
        return w;
    endfunction

    function automatic block_t sub_fwd(input block_t v);
        block_t w;
        for (int i = 0; i < 16; i++) w[8*i +: 8] = SBOX[v[8*i +: 8]];
        return w;
    endfunction

    function automatic block_t sub_inv(input block_t v);
        block_t w;
        for (int i = 0; i < 16; i++) w[8*i +: 8] = sbox_inv(v[8*i +: 8]);
        return w;
    endfunction

endpackage
`default_nettype wire

// File: hdl/kuz_datapath.sv
// Kuznyechik datapath: key registers, key expansion, round key store, round unit.
// Depends on kuz_pkg.
`default_nettype none
module kuz_datapath #(
    parameter int ROUND_KEY_COUNT = kuz_pkg::RoundKeyCountDefault
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire kuz_pkg::kuz_cmd_t cmd,
    input  wire logic            cfg_we,
    input  wire logic [1:0]      cfg_sel,
    input  wire logic [63:0]     cfg_data,
    input  wire logic            blk_command,
    input  wire logic [63:0]     blk_hi,
    input  wire logic [63:0]     blk_lo,
    output logic [63:0]          key_word_q [4],
    output logic [63:0]          res_hi,
    output logic [63:0]          res_lo
);
    import kuz_pkg::*;

    logic [63:0] key_reg [4];
    block_t exp_a_reg, exp_b_reg;
    block_t rk_reg [ROUND_KEY_COUNT];
    block_t state_reg;
    logic   dec_reg;
    block_t res_reg;

    block_t exp_c, exp_t, rk_cur, after_key, enc_next, dec_next;

    assign exp_c = lin_fwd({120'd0, 2'd0, cmd.exp_const});
    assign exp_t = lin_fwd(sub_fwd(exp_a_reg ^ exp_c)) ^ exp_b_reg;
    assign rk_cur = rk_reg[cmd.rk_idx];
    assign after_key = state_reg ^ rk_cur;
    assign enc_next = lin_fwd(sub_fwd(after_key));
    assign dec_next = sub_inv(lin_inv(after_key));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            key_reg[0] <= 64'd0;
            key_reg[1] <= 64'd0;
            key_reg[2] <= 64'd0;
            key_reg[3] <= 64'd0;
        end else if (cfg_we) begin
            key_reg[cfg_sel] <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.key_load) begin
            exp_a_reg <= {key_reg[0], key_reg[1]};
            exp_b_reg <= {key_reg[2], key_reg[3]};
            rk_reg[0] <= {key_reg[0], key_reg[1]};
            rk_reg[1] <= {key_reg[2], key_reg[3]};
        end
        if (cmd.exp_step) begin
            exp_a_reg <= exp_t;
            exp_b_reg <= exp_a_reg;
        end
        if (cmd.exp_store) begin
            rk_reg[{cmd.exp_pair[2:0], 1'b0}] <= exp_a_reg;
            rk_reg[{cmd.exp_pair[2:0], 1'b1}] <= exp_b_reg;
        end
        if (cmd.blk_load) begin
            state_reg <= {blk_hi, blk_lo};
            dec_reg <= blk_command;
        end
        if (cmd.blk_round) state_reg <= (dec_reg == CmdDecrypt) ? dec_next : enc_next;
        if (cmd.blk_final) res_reg <= after_key;
    end

    assign key_word_q = key_reg;
    assign res_hi = res_reg[127:64];
    assign res_lo = res_reg[63:0];
endmodule
`default_nettype wire

// File: hdl/kuz_control.sv
// Kuznyechik controller: key expansion sequencing and block round sequencing.
// Depends on kuz_pkg.
`default_nettype none
module kuz_control #(
    parameter int ROUND_KEY_COUNT = kuz_pkg::RoundKeyCountDefault
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  rekey,
    input  wire logic  in_valid,
    input  wire logic  in_cmd,
    output logic       in_stall,
    output logic       out_valid,
    input  wire logic  out_stall,
    output kuz_pkg::kuz_cmd_t cmd
);
    import kuz_pkg::*;

    typedef enum logic [4:0] {
        ST_LOAD  = 5'b00001,
        ST_EXP   = 5'b00010,
        ST_IDLE  = 5'b00100,
        ST_RUN   = 5'b01000,
        ST_FIN   = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic [4:0] step_reg, step_next;    // expansion step 0..31 / round counter
    logic dec_reg, dec_next;
    logic ov_reg, ov_next;
    logic pending_reg, pending_next;
    logic exp_store_q;
    logic [3:0] exp_pair_q;

    always_comb
    begin
        state_next = state_reg;
        step_next = step_reg;
        dec_next = dec_reg;
        ov_next = ov_reg;
        pending_next = pending_reg | rekey;
        cmd = '0;
        in_stall = 1'b1;
        if (ov_reg && !out_stall) ov_next = 1'b0;
        case (state_reg)
            ST_LOAD:
            begin
                cmd.key_load = 1'b1;
                pending_next = rekey;
                step_next = 5'd0;
                state_next = ST_EXP;
            end
            ST_EXP:
            begin
                cmd.exp_step = 1'b1;
                cmd.exp_const = {1'b0, step_reg} + 6'd1;
                step_next = step_reg + 5'd1;
                if (step_reg == 5'd31) state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (pending_reg) state_next = ST_LOAD;
                else begin
                    in_stall = 1'b0;
                    if (in_valid) begin
                        dec_next = in_cmd;
                        step_next = 5'd0;
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                cmd.blk_round = 1'b1;
                cmd.rk_idx = (dec_reg == CmdDecrypt) ? 4'(ROUND_KEY_COUNT - 1) - step_reg[3:0]
                                                     : step_reg[3:0];
                step_next = step_reg + 5'd1;
                if (step_reg == 5'(ROUND_KEY_COUNT - 2)) state_next = ST_FIN;
            end
            ST_FIN:
            begin
                cmd.rk_idx = (dec_reg == CmdDecrypt) ? 4'd0 : 4'(ROUND_KEY_COUNT - 1);
                if (!ov_reg || !out_stall) begin
                    cmd.blk_final = 1'b1;
                    ov_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_LOAD;
        endcase
        cmd.blk_load = (state_reg == ST_IDLE) && !pending_reg && in_valid;
        // a/b pair is stored after every eighth step, using the registers after that step
        cmd.exp_store = (state_reg == ST_EXP || state_reg == ST_IDLE) && exp_store_q;
        cmd.exp_pair = exp_pair_q;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_LOAD;
            step_reg <= 5'd0;
            dec_reg <= 1'b0;
            ov_reg <= 1'b0;
            pending_reg <= 1'b0;
            exp_store_q <= 1'b0;
            exp_pair_q <= 4'd0;
        end else begin
            state_reg <= state_next;
            step_reg <= step_next;
            dec_reg <= dec_next;
            ov_reg <= ov_next;
            pending_reg <= pending_next;
            exp_store_q <= (state_reg == ST_EXP) && (step_reg[2:0] == 3'd7);
            exp_pair_q <= {2'b00, step_reg[4:3]} + 4'd1;
        end
    end

    assign out_valid = ov_reg;
endmodule
`default_nettype wire

// File: hdl/kuznyechik_block_cipher.sv
// Kuznyechik block cipher top level: APB key port, block channels.
// Depends on kuz_pkg, kuz_control, kuz_datapath.
//
// Usage: write the 256-bit key as four 64-bit registers over APB (byte addresses
// 0, 8, 16, 24). A write restarts key expansion once the block is idle: the
// write is registered as pending, then the load step and 32 Feistel steps run,
// with in_stall high throughout. Reset loads the all-zero key and runs the load
// step plus 32 Feistel steps before the first item is taken.
// Input item: command (0 encrypt, 1 decrypt) with data_hi/data_lo, taken when
// in_valid is high and in_stall low. Nine rounds run on the shared round unit,
// then the final key add into the output register raises out_valid; in_stall
// stays high until then, so the next item is taken only after that.
// Output: result_hi/result_lo held stable while out_valid is high and out_stall
// is high; the next item's work proceeds meanwhile and waits only at the
// final step if the earlier result is still not taken.
`default_nettype none
module kuznyechik_block_cipher #(
    parameter int ROUND_KEY_COUNT = kuz_pkg::RoundKeyCountDefault
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [kuz_pkg::AddrWidth-1:0] paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        command,
    input  wire logic [63:0] data_hi,
    input  wire logic [63:0] data_lo,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [63:0]      result_hi,
    output logic [63:0]      result_lo
);
    import kuz_pkg::*;

    kuz_cmd_t cmd;
    logic [63:0] key_q [4];
    logic wr_key;
    logic [1:0] reg_idx;

    assign pready = 1'b1;
    assign reg_idx = paddr[AddrWidth-1:3];
    assign wr_key = psel && penable && pwrite;

    always_comb
    begin
        case (reg_idx)
            RegKey0: prdata = key_q[0];
            RegKey1: prdata = key_q[1];
            RegKey2: prdata = key_q[2];
            RegKey3: prdata = key_q[3];
            default: prdata = 64'd0;
        endcase
    end

    kuz_control #(.ROUND_KEY_COUNT(ROUND_KEY_COUNT)) u_ctrl (
        .clk(clk), .rst_n(rst_n), .rekey(wr_key),
        .in_valid(in_valid), .in_cmd(command), .in_stall(in_stall),
        .out_valid(out_valid), .out_stall(out_stall), .cmd(cmd)
    );

    kuz_datapath #(.ROUND_KEY_COUNT(ROUND_KEY_COUNT)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .cfg_we(wr_key), .cfg_sel(reg_idx),
        .cfg_data(pwdata), .blk_command(command), .blk_hi(data_hi), .blk_lo(data_lo),
        .key_word_q(key_q), .res_hi(result_hi), .res_lo(result_lo)
    );
endmodule
`default_nettype wire

// File: hdl/kuz_checker.sv
// Port-level checker for kuznyechik_block_cipher, with bind.
// Depends on the top level's ports only.
`default_nettype none
module kuz_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_stall,
    input wire logic out_valid,
    input wire logic out_stall,
    input wire logic [63:0] result_hi,
    input wire logic [63:0] result_lo,
    input wire logic pready
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(result_hi) && $stable(result_lo))
        else $error("result changed while stalled");
    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> !out_valid || $past(out_valid))
        else $error("result too early");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second item taken during work");
    a_ready: assert property (@(posedge clk) pready)
        else $error("pready low");
endmodule

bind kuznyechik_block_cipher kuz_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall),
    .result_hi(result_hi), .result_lo(result_lo), .pready(pready)
);
`default_nettype wire
